[sv/wia_pkg.sv]
// ----------------------------------------------------------------------------
// wia_pkg
// Shared widths and action codes for the wide integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package wia_pkg;

  localparam int WIDE_W  = 64;  // operand and result width
  localparam int WORD_W  = 32;  // width scanned by the highest-set-bit action
  localparam int ACT_W   = 3;
  localparam int SHAMT_W = 7;   // signed shift amount, -64..63 encodable
  localparam int SHIDX_W = $clog2(WIDE_W);
  localparam int BITIX_W = $clog2(WORD_W);

  typedef enum logic [ACT_W-1:0] {
    ACT_CMP = 3'd0,
    ACT_NEG = 3'd1,
    ACT_SHF = 3'd2,
    ACT_ADD = 3'd3,
    ACT_SUB = 3'd4,
    ACT_HSB = 3'd5
  } action_t;

endpackage

`default_nettype wire

[sv/wia_if.sv]
// ----------------------------------------------------------------------------
// wia_in_if / wia_out_if
// Valid/ready channels carrying ALU requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wia_in_if;
  logic                              valid;
  logic                              ready;
  logic [wia_pkg::ACT_W-1:0]         action;
  logic signed [wia_pkg::WIDE_W-1:0] operand_a;
  logic signed [wia_pkg::WIDE_W-1:0] operand_b;
  logic signed [wia_pkg::SHAMT_W-1:0] shift_amount;

  modport source (output valid, action, operand_a, operand_b, shift_amount,
                  input ready);
  modport sink   (input valid, action, operand_a, operand_b, shift_amount,
                  output ready);
endinterface

interface wia_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wia_pkg::WIDE_W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

[sv/wide_integer_alu_unit.sv]
// ----------------------------------------------------------------------------
// wide_integer_alu_unit
// Path: a request is registered in the request stage, then its result in the result stage, which offers it.
// Throughput: one item per cycle; the pipeline only stalls on out_ch.ready.
// Reset: synchronous active-low rst_n clears both stage valid flags;
// payload registers are not reset. No other state exists.
// ----------------------------------------------------------------------------
`default_nettype none

module wide_integer_alu_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wia_in_if.sink     in_ch,
  wia_out_if.source  out_ch
);

  // Stage 1: registered request
  logic                               in_v_r;
  logic [wia_pkg::ACT_W-1:0]          act_r;
  logic signed [wia_pkg::WIDE_W-1:0]  a_r;
  logic signed [wia_pkg::WIDE_W-1:0]  b_r;
  logic signed [wia_pkg::SHAMT_W-1:0] sh_r;

  // Stage 2: result register, doubles as the output holding stage
  logic                               out_v_r;
  logic signed [wia_pkg::WIDE_W-1:0]  res_r;
  logic signed [wia_pkg::WIDE_W-1:0]  res_nxt;

  logic s2_load;
  logic s1_load;

  // The result stage moves whenever it is empty or its item is being taken;
  // the request stage moves whenever it is empty or its item moves on.
  assign s2_load     = !out_v_r || out_ch.ready;
  assign s1_load     = !in_v_r || s2_load;
  assign in_ch.ready = s1_load;

  wia_core u_core (
    .action       (act_r),
    .operand_a    (a_r),
    .operand_b    (b_r),
    .shift_amount (sh_r),
    .result       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_load) begin
        in_v_r <= in_ch.valid;
      end
      if (s2_load) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_ch.valid) begin
      act_r <= in_ch.action;
      a_r   <= in_ch.operand_a;
      b_r   <= in_ch.operand_b;
      sh_r  <= in_ch.shift_amount;
    end
    if (s2_load && in_v_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.result = res_r;

endmodule

`default_nettype wire

[sv/wia_core.sv]
// ----------------------------------------------------------------------------
// wia_core
// Combinational datapath: compare, negate, rounding shift, add, subtract and
// highest-set-bit scan on 64-bit two's complement operands.
// ----------------------------------------------------------------------------
`default_nettype none

module wia_core (
  input  wire logic [wia_pkg::ACT_W-1:0]          action,
  input  wire logic signed [wia_pkg::WIDE_W-1:0]  operand_a,
  input  wire logic signed [wia_pkg::WIDE_W-1:0]  operand_b,
  input  wire logic signed [wia_pkg::SHAMT_W-1:0] shift_amount,
  output logic signed [wia_pkg::WIDE_W-1:0]       result
);

  logic [wia_pkg::SHIDX_W-1:0]       sh_pos;
  logic [wia_pkg::SHIDX_W-1:0]       sh_left;
  logic [wia_pkg::SHAMT_W-1:0]       sh_neg;
  logic signed [wia_pkg::WIDE_W-1:0] shr;
  logic                              rnd_bit;
  logic signed [wia_pkg::WIDE_W-1:0] shift_res;
  logic signed [wia_pkg::WIDE_W-1:0] cmp_res;
  logic [wia_pkg::BITIX_W-1:0]       hsb_idx;
  logic                              hsb_any;
  logic signed [wia_pkg::WIDE_W-1:0] hsb_res;

  // Right shift: arithmetic, rounded by the last bit shifted out
  assign sh_pos  = shift_amount[wia_pkg::SHIDX_W-1:0];
  assign shr     = operand_a >>> sh_pos;
  assign rnd_bit = operand_a[sh_pos - wia_pkg::SHIDX_W'(1)];

  // Left shift: magnitude of a negative amount, -64 saturates to 63
  assign sh_neg  = -shift_amount;
  assign sh_left = sh_neg[wia_pkg::SHAMT_W-1] ? {wia_pkg::SHIDX_W{1'b1}}
                                              : sh_neg[wia_pkg::SHIDX_W-1:0];

  always_comb begin
    if (shift_amount[wia_pkg::SHAMT_W-1]) begin
      shift_res = operand_a << sh_left;
    end else if (sh_pos == '0) begin
      shift_res = operand_a;
    end else begin
      shift_res = shr + wia_pkg::WIDE_W'(rnd_bit);
    end
  end

  always_comb begin
    if (operand_a > operand_b) begin
      cmp_res = wia_pkg::WIDE_W'(1);
    end else if (operand_a < operand_b) begin
      cmp_res = '1;
    end else begin
      cmp_res = '0;
    end
  end

  // Priority encoder over the low word, highest bit wins
  always_comb begin
    hsb_idx = '0;
    hsb_any = 1'b0;
    for (int i = 0; i < wia_pkg::WORD_W; i++) begin
      if (operand_a[i]) begin
        hsb_idx = wia_pkg::BITIX_W'(i);
        hsb_any = 1'b1;
      end
    end
    hsb_res = hsb_any ? $signed(wia_pkg::WIDE_W'(hsb_idx)) : '1;
  end

  always_comb begin
    case (wia_pkg::action_t'(action))
      wia_pkg::ACT_CMP: result = cmp_res;
      wia_pkg::ACT_NEG: result = -operand_a;
      wia_pkg::ACT_SHF: result = shift_res;
      wia_pkg::ACT_ADD: result = operand_a + operand_b;
      wia_pkg::ACT_SUB: result = operand_a - operand_b;
      wia_pkg::ACT_HSB: result = hsb_res;
      default:          result = '0;
    endcase
  end

endmodule

`default_nettype wire

[tb/sv/wide_integer_alu_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_integer_alu_unit_tb
// Self-checking bench for the 64-bit ALU: every accepted request is run
// through a local model of the ALU, and each result transfer is checked
// against the oldest outstanding prediction. Directed corner cases come
// first, then random traffic with idling on both sides, a long output
// stall, a full drain, and a back-to-back stretch at the end.
// ----------------------------------------------------------------------------

module wide_integer_alu_unit_tb;

  // Run guard: far above the slowest legal run (worst sender gaps and
  // receiver stalls, plus the long hold-off).
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_PRINTS  = 100;

  localparam logic [wia_pkg::WIDE_W-1:0] MIN_S = {1'b1, {(wia_pkg::WIDE_W-1){1'b0}}};
  localparam logic [wia_pkg::WIDE_W-1:0] MAX_S = {1'b0, {(wia_pkg::WIDE_W-1){1'b1}}};
  localparam logic [wia_pkg::WIDE_W-1:0] ALL_1 = '1;

  // Action codes above the last defined one produce a zero result.
  localparam logic [wia_pkg::ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [wia_pkg::ACT_W-1:0] ACT_SPARE7 = 3'd7;

  typedef struct {
    logic [wia_pkg::ACT_W-1:0]   act;
    logic [wia_pkg::WIDE_W-1:0]  a;
    logic [wia_pkg::WIDE_W-1:0]  b;
    logic [wia_pkg::SHAMT_W-1:0] sh;
    logic [wia_pkg::WIDE_W-1:0]  res;
  } alu_op_t;

  logic clk;
  logic rst_n;

  wia_in_if  in_ch();
  wia_out_if out_ch();

  wide_integer_alu_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Requests accepted but whose results have not yet come back, oldest first.
  alu_op_t pending_results[$];

  int error_count   = 0;
  int checked_count = 0;
  int sent_count    = 0;
  int cycle_count   = 0;

  // Random idling on both sides; cleared for the final back-to-back stretch.
  logic idle_en  = 1'b0;
  // Long receiver hold-off, in cycles; picked up by the ready process.
  int   hold_req = 0;

  // --------------------------------------------------------------------------
  // Clock and run guard
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Expected-result calculation
  // --------------------------------------------------------------------------
  function automatic logic [wia_pkg::WIDE_W-1:0] alu_expected(
      logic [wia_pkg::ACT_W-1:0]   act,
      logic [wia_pkg::WIDE_W-1:0]  a,
      logic [wia_pkg::WIDE_W-1:0]  b,
      logic [wia_pkg::SHAMT_W-1:0] sh);
    logic [wia_pkg::WIDE_W-1:0] r;
    logic [wia_pkg::WIDE_W-1:0] shr;
    int amt;
    amt = $signed(sh);
    r   = '0;
    shr = '0;
    case (act)
      wia_pkg::ACT_CMP: begin
        if ($signed(a) > $signed(b))      r = 64'd1;
        else if ($signed(a) < $signed(b)) r = ALL_1;
        else                              r = '0;
      end
      wia_pkg::ACT_NEG: r = -a;
      wia_pkg::ACT_SHF: begin
        // right: arithmetic shift, then add the last bit shifted out
        // left: logical, amount clamped to 63 (so -64 acts as -63)
        if (amt > 0) begin
          shr = $signed(a) >>> amt;
          r   = shr + {63'd0, a[amt-1]};
        end else if (amt < 0) begin
          r = a << ((amt < -63) ? 63 : -amt);
        end else begin
          r = a;
        end
      end
      wia_pkg::ACT_ADD: r = a + b;
      wia_pkg::ACT_SUB: r = a - b;
      wia_pkg::ACT_HSB: begin
        r = ALL_1;
        for (int k = 0; k < wia_pkg::WORD_W; k++)
          if (a[k]) r = wia_pkg::WIDE_W'(k);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every output transfer is matched with the oldest request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    alu_op_t op;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_ch.result));
      end else begin
        op = pending_results.pop_front();
        checked_count++;
        if (out_ch.result !== op.res)
          report_mismatch($sformatf(
            "act=%0d a=%h b=%h sh=%0d result=%h expected=%h",
            op.act, op.a, op.b, $signed(op.sh), out_ch.result, op.res));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : ready_driver
    int hold_left;
    int stall_left;
    hold_left    = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req <= 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: one request, entered and left at a falling edge. Valid stays
  // high between back-to-back transfers; with idling on, a random gap
  // drops it low first.
  // --------------------------------------------------------------------------
  task automatic send_op(logic [wia_pkg::ACT_W-1:0]   act,
                         logic [wia_pkg::WIDE_W-1:0]  a,
                         logic [wia_pkg::WIDE_W-1:0]  b,
                         logic [wia_pkg::SHAMT_W-1:0] sh);
    alu_op_t op;
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.operand_a    <= a;
    in_ch.operand_b    <= b;
    in_ch.shift_amount <= sh;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    op.act = act;
    op.a   = a;
    op.b   = b;
    op.sh  = sh;
    op.res = alu_expected(act, a, b, sh);
    pending_results.push_back(op);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Operand mix: corner values, small signed numbers, single bits, random.
  function automatic logic [wia_pkg::WIDE_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_1;
      2:       return MIN_S;
      3:       return MAX_S;
      4:       return wia_pkg::WIDE_W'($signed($urandom_range(0, 63)) - 32);
      5:       return 64'd1 << $urandom_range(0, wia_pkg::WIDE_W - 1);
      6:       return {32'd0, $urandom} >> $urandom_range(0, 31);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_op();
    logic [wia_pkg::ACT_W-1:0]   act;
    logic [wia_pkg::WIDE_W-1:0]  a;
    logic [wia_pkg::WIDE_W-1:0]  b;
    logic [wia_pkg::SHAMT_W-1:0] sh;
    act = ($urandom_range(0, 15) == 0) ? wia_pkg::ACT_W'($urandom_range(6, 7))
                                       : wia_pkg::ACT_W'($urandom_range(0, 5));
    a = pick_operand();
    case ($urandom_range(0, 5))
      0:       b = a;                       // equal operands
      1:       b = {a[63:32], $urandom};    // same high word
      default: b = pick_operand();
    endcase
    // full 7-bit range, -64 included
    sh = wia_pkg::SHAMT_W'($urandom_range(0, 127));
    send_op(act, a, b, sh);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // compare: extremes, equality, low-word-only difference
    send_op(wia_pkg::ACT_CMP, MIN_S, MAX_S, '0);
    send_op(wia_pkg::ACT_CMP, MAX_S, MIN_S, '0);
    send_op(wia_pkg::ACT_CMP, 64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0, '0);
    send_op(wia_pkg::ACT_CMP, 64'h0000_0001_0000_0000, 64'h0000_0001_FFFF_FFFF, '0);
    send_op(wia_pkg::ACT_CMP, ALL_1, 64'd0, 7'h3F);
    // negate: most negative wraps to itself
    send_op(wia_pkg::ACT_NEG, MIN_S, ALL_1, 7'h15);
    send_op(wia_pkg::ACT_NEG, 64'd0, '0, '0);
    send_op(wia_pkg::ACT_NEG, 64'd1, '0, '0);
    // add / subtract with wraparound
    send_op(wia_pkg::ACT_ADD, MAX_S, 64'd1, '0);
    send_op(wia_pkg::ACT_ADD, MIN_S, ALL_1, '0);
    send_op(wia_pkg::ACT_SUB, MIN_S, 64'd1, '0);
    send_op(wia_pkg::ACT_SUB, 64'd0, MIN_S, '0);
    // shift: rounding right, zero, left, and the -64 saturation
    send_op(wia_pkg::ACT_SHF, 64'd5, ALL_1, 7'sd1);
    send_op(wia_pkg::ACT_SHF, ALL_1, '0, 7'sd63);
    send_op(wia_pkg::ACT_SHF, MIN_S, '0, 7'sd63);
    send_op(wia_pkg::ACT_SHF, MAX_S, '0, 7'sd63);
    send_op(wia_pkg::ACT_SHF, 64'hDEAD_BEEF_0BAD_F00D, '0, 7'sd0);
    send_op(wia_pkg::ACT_SHF, ALL_1, '0, -7'sd1);
    send_op(wia_pkg::ACT_SHF, 64'h0000_0000_0000_0003, '0, -7'sd63);
    send_op(wia_pkg::ACT_SHF, 64'h0000_0000_0000_0003, '0, 7'h40);
    // highest set bit of the low word: zero low word with high bits set, top and bottom bits, bit 0 alone
    send_op(wia_pkg::ACT_HSB, 64'hFFFF_FFFF_0000_0000, '0, '0);
    send_op(wia_pkg::ACT_HSB, 64'h0000_0000_8000_0001, '0, '0);
    send_op(wia_pkg::ACT_HSB, 64'd1, '0, '0);
    // spare codes give zero whatever the operands
    send_op(ACT_SPARE6, ALL_1, ALL_1, 7'h7F);
    send_op(ACT_SPARE7, MAX_S, MIN_S, 7'h40);
  endtask

  task automatic test_random_mix(int n_items);
    idle_en <= 1'b1;
    repeat (n_items) send_random_op();
  endtask

  // Output held off for a long stretch while requests keep coming, so the
  // pipeline fills and in_ch.ready drops; then the sender waits for a full
  // drain before moving on.
  task automatic test_output_hold(int n_items, int hold_cycles);
    idle_en  <= 1'b0;
    hold_req <= hold_cycles;
    repeat (n_items) send_random_op();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    wait_for_results();
  endtask

  task automatic test_full_rate(int n_items);
    idle_en <= 1'b0;
    repeat (n_items) send_random_op();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = '0;
    in_ch.operand_a    = '0;
    in_ch.operand_b    = '0;
    in_ch.shift_amount = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_mix(1300);
    test_output_hold(40, 60);
    test_full_rate(180);

    in_ch.valid <= 1'b0;
    wait_for_results();
    // wait on for stray transfers before the summary
    repeat (8) @(posedge clk);

    $display("Sent %0d requests, checked %0d results, %0d mismatches",
             sent_count, checked_count, error_count);
    $display("Covered all actions, spare codes, shift clamp, idling, long hold-off");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
